>>> sv/mcpwm_pkg.sv
// ----------------------------------------------------------------------------
// mcpwm_pkg
// Shared constants, transaction types and the window compare used by the
// multichannel PWM generator.
// ----------------------------------------------------------------------------
package mcpwm_pkg;

   localparam int CHANNELS        = 16;
   localparam int COUNTER_BITS    = 12;
   localparam int WORD_BITS       = COUNTER_BITS + 1;
   localparam int FIELD_WORD_BITS = 13;
   localparam int CHANNEL_BITS    = 4;
   localparam int LEVEL_BITS      = 16;
   localparam int LEVEL_CHANNELS  = (CHANNELS < LEVEL_BITS) ? CHANNELS : LEVEL_BITS;
   localparam int PRESCALE_BITS   = 8;
   localparam int PRESCALE_RESET  = 30;
   localparam int PRESCALE_MIN    = 3;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 8;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PRESCALE = 1'b0,
      CSR_SLEEP    = 1'b1
   } csr_index_type;

   typedef logic [WORD_BITS-1:0]    word_type;
   typedef logic [COUNTER_BITS-1:0] count_type;

   typedef struct packed {
      logic [1:0]                 op;
      logic [CHANNEL_BITS-1:0]    channel;
      logic [FIELD_WORD_BITS-1:0] on_count;
      logic [FIELD_WORD_BITS-1:0] off_count;
   } req_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0]      pwm_levels;
      logic [FIELD_WORD_BITS-1:0] read_on;
      logic [FIELD_WORD_BITS-1:0] read_off;
   } rsp_type;

   // Full-off beats full-on; otherwise high inside [on, off), wrapping.
   function automatic logic channel_level(word_type on_w, word_type off_w, count_type cnt);
      count_type a;
      count_type b;
      logic      lvl;
      a = on_w[COUNTER_BITS-1:0];
      b = off_w[COUNTER_BITS-1:0];
      if (off_w[COUNTER_BITS]) begin
         lvl = 1'b0;
      end else if (on_w[COUNTER_BITS]) begin
         lvl = 1'b1;
      end else if (a == b) begin
         lvl = 1'b0;
      end else if (a < b) begin
         lvl = (cnt >= a) && (cnt < b);
      end else begin
         lvl = (cnt >= a) || (cnt < b);
      end
      return lvl;
   endfunction

endpackage

>>> sv/mcpwm_timebase.sv
// ----------------------------------------------------------------------------
// mcpwm_timebase
// Configuration registers, prescaler and shared cycle counter.
// ----------------------------------------------------------------------------
module mcpwm_timebase
   import mcpwm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      tick_i,
   output count_type                 count_next_o
);

   logic [PRESCALE_BITS-1:0] prescale_ff, prescale_in;
   logic                     sleep_ff, sleep_in;
   logic [PRESCALE_BITS-1:0] pscnt_ff, pscnt_in;
   count_type                count_ff, count_in;
   logic                     advance;
   logic                     wrap;

   always_comb begin
      prescale_in = prescale_ff;
      sleep_in    = sleep_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PRESCALE: begin
               // clamp to the hardware minimum
               if (csr_wdata[PRESCALE_BITS-1:0] < PRESCALE_BITS'(PRESCALE_MIN)) begin
                  prescale_in = PRESCALE_BITS'(PRESCALE_MIN);
               end else begin
                  prescale_in = csr_wdata[PRESCALE_BITS-1:0];
               end
            end
            CSR_SLEEP: begin
               sleep_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign advance = tick_i && !sleep_ff;
   assign wrap    = pscnt_ff >= prescale_ff;

   always_comb begin
      pscnt_in = pscnt_ff;
      count_in = count_ff;
      if (advance) begin
         if (wrap) begin
            pscnt_in = '0;
            count_in = count_ff + 1'b1;
         end else begin
            pscnt_in = pscnt_ff + 1'b1;
         end
      end
   end

   assign count_next_o = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= PRESCALE_BITS'(PRESCALE_RESET);
         sleep_ff    <= 1'b1;
         pscnt_ff    <= '0;
         count_ff    <= '0;
      end else begin
         prescale_ff <= prescale_in;
         sleep_ff    <= sleep_in;
         pscnt_ff    <= pscnt_in;
         count_ff    <= count_in;
      end
   end

   a_count_frozen: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff))
      else $error("cycle counter moved without an awake tick");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (advance && wrap) |=> (count_ff == COUNTER_BITS'($past(count_ff) + 1'b1)))
      else $error("cycle counter did not step on prescaler wrap");

   a_pscnt_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && wrap) |=> (pscnt_ff == '0))
      else $error("prescaler not cleared on wrap");

endmodule

>>> sv/mcpwm_chan_regs.sv
// ----------------------------------------------------------------------------
// mcpwm_chan_regs
// On and off word registers of every channel, with write and readback.
// ----------------------------------------------------------------------------
module mcpwm_chan_regs
   import mcpwm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    write_i,
   input  logic                    read_i,
   input  logic [CHANNEL_BITS-1:0] channel_i,
   input  word_type                on_word_i,
   input  word_type                off_word_i,
   output word_type                on_next_o  [CHANNELS],
   output word_type                off_next_o [CHANNELS],
   output word_type                rd_on_o,
   output word_type                rd_off_o
);

   word_type on_ff  [CHANNELS];
   word_type off_ff [CHANNELS];
   word_type on_in  [CHANNELS];
   word_type off_in [CHANNELS];
   logic [CHANNELS-1:0] hit;

   // channels beyond the array never match, so writes drop and reads give zero
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         hit[i] = (int'(channel_i) == i);
      end
   end

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         on_in[i]  = on_ff[i];
         off_in[i] = off_ff[i];
         if (write_i && hit[i]) begin
            on_in[i]  = on_word_i;
            off_in[i] = off_word_i;
         end
      end
   end

   always_comb begin
      rd_on_o  = '0;
      rd_off_o = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (read_i && hit[i]) begin
            rd_on_o  = on_ff[i];
            rd_off_o = off_ff[i];
         end
      end
   end

   assign on_next_o  = on_in;
   assign off_next_o = off_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            on_ff[i]  <= '0;
            off_ff[i] <= word_type'(1) << COUNTER_BITS;
         end
      end else begin
         for (int i = 0; i < CHANNELS; i++) begin
            on_ff[i]  <= on_in[i];
            off_ff[i] <= off_in[i];
         end
      end
   end

   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      (write_i && hit[0]) |=> (on_ff[0] == $past(on_word_i) && off_ff[0] == $past(off_word_i)))
      else $error("channel 0 write not stored");

endmodule

>>> sv/mcpwm_levels.sv
// ----------------------------------------------------------------------------
// mcpwm_levels
// Parallel window compare of every channel against the shared counter.
// ----------------------------------------------------------------------------
module mcpwm_levels
   import mcpwm_pkg::*;
(
   input  word_type            on_words_i  [CHANNELS],
   input  word_type            off_words_i [CHANNELS],
   input  count_type           count_i,
   output logic [CHANNELS-1:0] levels_o
);

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         levels_o[i] = channel_level(on_words_i[i], off_words_i[i], count_i);
      end
   end

endmodule

>>> sv/multichannel_pwm_generator_top.sv
// ----------------------------------------------------------------------------
// multichannel_pwm_generator_top
// Multichannel PWM generator: channel word store, prescaled counter and a
// registered result of all channel levels plus readback.
//
//   port group | dir | handshake            | payload
//   req_*      | in  | req_valid/req_stall  | req_payload  (op, channel, words)
//   rsp_*      | out | rsp_valid/rsp_stall  | rsp_payload  (levels, readback)
//   csr_*      | in  | csr_we               | csr_index, csr_wdata
//
// One transaction per cycle while not stalled; its result is registered and
// appears in the cycle after acceptance. State is updated at acceptance and
// levels are taken from the updated state into that single result register.
// A held result stalls the request side only while rsp_stall is high.
// Synchronous reset: words cleared with full-off set, counters at zero,
// prescale 30, sleep set.
// ----------------------------------------------------------------------------
module multichannel_pwm_generator_top
   import mcpwm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_payload,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                accept;
   logic                tick;
   logic                wr;
   logic                rd;
   count_type           count_next;
   word_type            on_next  [CHANNELS];
   word_type            off_next [CHANNELS];
   word_type            rd_on;
   word_type            rd_off;
   logic [CHANNELS-1:0] levels;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign tick      = accept && (req_payload.op == OP_TICK);
   assign wr        = accept && (req_payload.op == OP_WRITE);
   assign rd        = accept && (req_payload.op == OP_READ);

   mcpwm_timebase u_timebase (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .tick_i       (tick),
      .count_next_o (count_next)
   );

   mcpwm_chan_regs u_chan_regs (
      .clock      (clock),
      .reset      (reset),
      .write_i    (wr),
      .read_i     (rd),
      .channel_i  (req_payload.channel),
      .on_word_i  (word_type'(req_payload.on_count)),
      .off_word_i (word_type'(req_payload.off_count)),
      .on_next_o  (on_next),
      .off_next_o (off_next),
      .rd_on_o    (rd_on),
      .rd_off_o   (rd_off)
   );

   mcpwm_levels u_levels (
      .on_words_i  (on_next),
      .off_words_i (off_next),
      .count_i     (count_next),
      .levels_o    (levels)
   );

   always_comb begin
      rsp_in = rsp_ff;
      if (accept) begin
         rsp_in.pwm_levels = '0;
         for (int i = 0; i < LEVEL_CHANNELS; i++) begin
            rsp_in.pwm_levels[i] = levels[i];
         end
         rsp_in.read_on  = FIELD_WORD_BITS'(rd_on);
         rsp_in.read_off = FIELD_WORD_BITS'(rd_off);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         // drop the result once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   a_no_readback_otherwise: assert property (@(posedge clock) disable iff (reset)
      (accept && !rd) |=> (rsp_ff.read_on == '0 && rsp_ff.read_off == '0))
      else $error("readback words set for a non-read transaction");

endmodule
